FILE: hdl/vlmt_pkg.sv
// shared types, constants and the arctangent table of the vertex link turning check
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vlmt_pkg;

	localparam int MAX_VERTICES_DEF = 256;
	localparam int MAX_RING_DEF = 16;
	localparam int COORD_W = 48;
	localparam int CORDIC_STEPS = 25;

	localparam logic signed [31:0] ANG_PI = 32'sd52707179;
	localparam logic signed [31:0] TURN_MAX = 32'sh7fffffff;

	localparam logic [1:0] CMD_COORD = 2'd0;
	localparam logic [1:0] CMD_RING = 2'd1;
	localparam logic [1:0] CMD_RUN = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] vertex;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_t;
		logic [3:0] ring_slot;
		logic [7:0] ring_neighbor;
		logic [4:0] ring_length;
	} vlmt_in_t;

	typedef struct packed {
		logic signed [31:0] min_turn;
		logic dent;
		logic none_checked;
	} vlmt_out_t;

	// arctangent of 2^-i in q8.24 radians
	function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
		case (idx)
			5'd0: atan_entry = 32'sd13176795;
			5'd1: atan_entry = 32'sd7778716;
			5'd2: atan_entry = 32'sd4110061;
			5'd3: atan_entry = 32'sd2086331;
			5'd4: atan_entry = 32'sd1047214;
			5'd5: atan_entry = 32'sd524117;
			5'd6: atan_entry = 32'sd262123;
			5'd7: atan_entry = 32'sd131069;
			5'd8: atan_entry = 32'sd65536;
			5'd9: atan_entry = 32'sd32768;
			5'd10: atan_entry = 32'sd16384;
			5'd11: atan_entry = 32'sd8192;
			5'd12: atan_entry = 32'sd4096;
			5'd13: atan_entry = 32'sd2048;
			5'd14: atan_entry = 32'sd1024;
			5'd15: atan_entry = 32'sd512;
			5'd16: atan_entry = 32'sd256;
			5'd17: atan_entry = 32'sd128;
			5'd18: atan_entry = 32'sd64;
			5'd19: atan_entry = 32'sd32;
			5'd20: atan_entry = 32'sd16;
			5'd21: atan_entry = 32'sd8;
			5'd22: atan_entry = 32'sd4;
			5'd23: atan_entry = 32'sd2;
			5'd24: atan_entry = 32'sd1;
			default: atan_entry = 32'sd0;
		endcase
	endfunction

endpackage

`default_nettype wire

FILE: hdl/vertex_link_min_turning.sv
// top level of the vertex link minimum turning check: loader, sequencer and shared datapath
// depends on vlmt_pkg and vlmt_ram
`timescale 1ns / 1ps
`default_nettype none

// Load items (coordinates, ring entries) are taken while the block is idle, and it is ready
// again at once. A run item walks vertices 1..vertex_count one after another through a
// single shared multiplier, a bit-serial square root, a bit-serial divider and a one-step
// CORDIC unit. A checked vertex with k ring entries takes a ring walk and bookkeeping, plus
// k directions and k spherical angles. One direction takes a normalizing shift of up to 29
// steps, four squaring steps, a 32-step square root and three 31-step divisions, all skipped
// when the neighbor sits on the vertex; one spherical angle takes three buffer reads, twenty
// multiply steps and 25 CORDIC steps, the CORDIC steps skipped when both atan2 inputs are
// zero. A vertex is skipped when its ring is empty, or after its ring walk when fewer than
// three entries are found. The input is not ready during a run, and a run that ends while an
// earlier result still waits holds until that result is taken. After reset a clearing pass
// over all MAX_VERTICES entries zeroes the ring length store before the first item is taken;
// configuration writes are accepted at any time.
module vertex_link_min_turning #(
	parameter int MAX_VERTICES = vlmt_pkg::MAX_VERTICES_DEF,
	parameter int MAX_RING = vlmt_pkg::MAX_RING_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire vlmt_pkg::vlmt_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output vlmt_pkg::vlmt_out_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [7:0]          cfg_data
);

	import vlmt_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int SW = $clog2(MAX_RING);
	localparam int LW = $clog2(MAX_RING + 1);
	localparam int RING_DEPTH = MAX_VERTICES * (1 << SW);
	localparam int MUL_LAST = 19;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_VRD, S_VCHK, S_WRD, S_WCHK, S_WEND, S_NRD, S_NCRD, S_DIFF,
		S_NORM, S_SQ, S_SQRT, S_DIV, S_DWR, S_A0, S_A1, S_A2, S_A3, S_MUL, S_CINIT,
		S_CORD, S_TURN, S_VEND, S_VNEXT, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		ACT_NONE, ACT_LOAD, ACT_ADD, ACT_CX, ACT_CY, ACT_CZ, ACT_NUM, ACT_AB, ACT_BC,
		ACT_AC, ACT_DEN
	} act_t;

	function automatic logic signed [31:0] clamp_dot(input logic signed [63:0] s);
		logic signed [63:0] sh;
		sh = s >>> 30;
		if (sh > 64'sd1073741824) begin
			clamp_dot = 32'sd1073741824;
		end else if (sh < -64'sd1073741824) begin
			clamp_dot = -32'sd1073741824;
		end else begin
			clamp_dot = sh[31:0];
		end
	endfunction

	// control
	state_t state_q;
	logic [VW-1:0] clr_q, v_q, nv_q;
	logic [LW-1:0] k_q, i_q;
	logic [4:0] step_q;
	logic [1:0] comp_q;
	logic [7:0] cfg_q;
	logic out_valid_q;
	vlmt_out_t out_data_q;
	logic signed [31:0] turn_q, least_q;
	logic checked_q;

	// datapath
	logic [LW-1:0] len_q;
	logic [7:0] start_q;
	logic [3*COORD_W-1:0] cv_q;
	logic nb_ok_q;
	logic [48:0] m_q [3];
	logic [2:0] neg_q;
	logic signed [31:0] dir_q [3];
	logic [62:0] sum_q, res_q, bit_q;
	logic [30:0] r_q, q_q;
	logic signed [31:0] a_q [3];
	logic signed [31:0] b_q [3];
	logic signed [31:0] c_q [3];
	logic signed [63:0] prod_q, acc_q, num_q;
	act_t act_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic signed [31:0] ab_q, bc_q, ac_q;
	logic signed [63:0] x_q, y_q;
	logic signed [31:0] z_q;

	// ram ports
	logic coord_we, ring_we, len_we;
	logic [VW-1:0] coord_waddr, coord_raddr, len_waddr;
	logic [VW+SW-1:0] ring_waddr, ring_raddr;
	logic [3*COORD_W-1:0] coord_rd;
	logic [7:0] ring_rd;
	logic [LW-1:0] len_wdata, len_rd;
	logic [SW-1:0] dir_raddr;
	logic [95:0] dir_rd;

	logic in_fire, in_v_ok;
	logic [VW-1:0] nv_w;
	logic [LW-1:0] in_len, prev_idx, next_idx, back_idx;

	logic signed [48:0] diff [3];
	logic [48:0] mag [3];
	logic mag_zero, big_hi, big_lo;

	logic signed [33:0] op_a, op_b;
	logic signed [67:0] prod;
	act_t cur_act;
	logic signed [63:0] acc_sum, acc_dif;

	logic [62:0] sq_trial;
	logic [31:0] div_t;
	logic div_ge;
	logic [30:0] q_n;
	logic signed [31:0] q_s;

	logic signed [63:0] cx0, cy0, xs, ys;
	logic signed [32:0] turn_sum;
	logic signed [31:0] turn_sat;

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign in_fire = in_valid && in_ready;
	assign in_v_ok = (32'(in_data.vertex) < MAX_VERTICES);
	assign nv_w = (32'(cfg_q) > MAX_VERTICES - 1) ? VW'(MAX_VERTICES - 1) : VW'(cfg_q);
	assign in_len = (32'(in_data.ring_length) > MAX_RING) ? LW'(MAX_RING)
		: LW'(in_data.ring_length);

	assign prev_idx = (i_q == '0) ? LW'(k_q - 1'b1) : LW'(i_q - 1'b1);
	assign next_idx = (LW'(i_q + 1'b1) == k_q) ? '0 : LW'(i_q + 1'b1);
	assign back_idx = LW'(k_q - i_q - 1'b1);

	// load writes, and the length clearing pass
	assign coord_we = in_fire && (in_data.cmd == CMD_COORD) && in_v_ok;
	assign coord_waddr = VW'(in_data.vertex);
	assign ring_we = in_fire && (in_data.cmd == CMD_RING) && in_v_ok
		&& (32'(in_data.ring_slot) < MAX_RING);
	assign ring_waddr = {VW'(in_data.vertex), SW'(in_data.ring_slot)};
	assign len_we = (state_q == S_CLEAR) || (in_fire && (in_data.cmd == CMD_RING) && in_v_ok);
	assign len_waddr = (state_q == S_CLEAR) ? clr_q : VW'(in_data.vertex);
	assign len_wdata = (state_q == S_CLEAR) ? '0 : in_len;

	always_comb begin
		coord_raddr = v_q;
		ring_raddr = {v_q, SW'(0)};
		dir_raddr = prev_idx[SW-1:0];
		case (state_q)
			S_WRD: ring_raddr = {v_q, k_q[SW-1:0]};
			S_NRD: ring_raddr = {v_q, back_idx[SW-1:0]};
			S_NCRD: coord_raddr = VW'(ring_rd);
			S_A1: dir_raddr = i_q[SW-1:0];
			S_A2: dir_raddr = next_idx[SW-1:0];
			default: ;
		endcase
	end

	vlmt_ram #(.WIDTH(3 * COORD_W), .DEPTH(MAX_VERTICES)) u_coord_ram (
		.clk(clk), .we(coord_we), .waddr(coord_waddr),
		.wdata({in_data.coord_t, in_data.coord_y, in_data.coord_x}),
		.raddr(coord_raddr), .rdata(coord_rd)
	);

	vlmt_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring_ram (
		.clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(in_data.ring_neighbor),
		.raddr(ring_raddr), .rdata(ring_rd)
	);

	vlmt_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_len_ram (
		.clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
		.raddr(v_q), .rdata(len_rd)
	);

	vlmt_ram #(.WIDTH(96), .DEPTH(MAX_RING)) u_dir_ram (
		.clk(clk), .we(state_q == S_DWR), .waddr(i_q[SW-1:0]),
		.wdata({dir_q[2], dir_q[1], dir_q[0]}),
		.raddr(dir_raddr), .rdata(dir_rd)
	);

	// neighbor minus center
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			diff[j] = (nb_ok_q ? 49'($signed(coord_rd[j*COORD_W +: COORD_W])) : 49'sd0)
				- 49'($signed(cv_q[j*COORD_W +: COORD_W]));
			mag[j] = diff[j][48] ? 49'(-diff[j]) : 49'(diff[j]);
		end
	end

	assign mag_zero = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
	assign big_hi = (|m_q[0][48:30]) || (|m_q[1][48:30]) || (|m_q[2][48:30]);
	assign big_lo = !((|m_q[0][48:29]) || (|m_q[1][48:29]) || (|m_q[2][48:29]));

	// shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		cur_act = ACT_NONE;
		if (state_q == S_SQ) begin
			if (step_q < 5'd3) begin
				op_a = $signed({4'b0, m_q[step_q[1:0]][29:0]});
				op_b = $signed({4'b0, m_q[step_q[1:0]][29:0]});
			end
		end else if (state_q == S_MUL) begin
			case (step_q)
				5'd0: begin op_a = 34'(b_q[1]); op_b = 34'(c_q[2]); cur_act = ACT_LOAD; end
				5'd1: begin op_a = 34'(b_q[2]); op_b = 34'(c_q[1]); cur_act = ACT_CX; end
				5'd2: begin op_a = 34'(b_q[2]); op_b = 34'(c_q[0]); cur_act = ACT_LOAD; end
				5'd3: begin op_a = 34'(b_q[0]); op_b = 34'(c_q[2]); cur_act = ACT_CY; end
				5'd4: begin op_a = 34'(b_q[0]); op_b = 34'(c_q[1]); cur_act = ACT_LOAD; end
				5'd5: begin op_a = 34'(b_q[1]); op_b = 34'(c_q[0]); cur_act = ACT_CZ; end
				5'd6: begin op_a = 34'(a_q[0]); op_b = cx_q; cur_act = ACT_LOAD; end
				5'd7: begin op_a = 34'(a_q[1]); op_b = cy_q; cur_act = ACT_ADD; end
				5'd8: begin op_a = 34'(a_q[2]); op_b = cz_q; cur_act = ACT_NUM; end
				5'd9: begin op_a = 34'(a_q[0]); op_b = 34'(b_q[0]); cur_act = ACT_LOAD; end
				5'd10: begin op_a = 34'(a_q[1]); op_b = 34'(b_q[1]); cur_act = ACT_ADD; end
				5'd11: begin op_a = 34'(a_q[2]); op_b = 34'(b_q[2]); cur_act = ACT_AB; end
				5'd12: begin op_a = 34'(b_q[0]); op_b = 34'(c_q[0]); cur_act = ACT_LOAD; end
				5'd13: begin op_a = 34'(b_q[1]); op_b = 34'(c_q[1]); cur_act = ACT_ADD; end
				5'd14: begin op_a = 34'(b_q[2]); op_b = 34'(c_q[2]); cur_act = ACT_BC; end
				5'd15: begin op_a = 34'(a_q[0]); op_b = 34'(c_q[0]); cur_act = ACT_LOAD; end
				5'd16: begin op_a = 34'(a_q[1]); op_b = 34'(c_q[1]); cur_act = ACT_ADD; end
				5'd17: begin op_a = 34'(a_q[2]); op_b = 34'(c_q[2]); cur_act = ACT_AC; end
				5'd18: begin op_a = 34'(ab_q); op_b = 34'(bc_q); cur_act = ACT_DEN; end
				default: ;
			endcase
		end
	end

	assign prod = op_a * op_b;
	assign acc_sum = acc_q + prod_q;
	assign acc_dif = acc_q - prod_q;

	// square root, division and cordic steps
	assign sq_trial = res_q + bit_q;
	assign div_t = (step_q == '0) ? {2'b0, m_q[comp_q][29:0]} : {r_q, 1'b0};
	assign div_ge = (div_t >= {1'b0, res_q[30:0]});
	assign q_n = {q_q[29:0], div_ge};
	assign q_s = $signed({1'b0, q_n});

	assign cy0 = num_q >>> 2;
	assign cx0 = acc_q >>> 2;
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;

	assign turn_sum = 33'(turn_q) + 33'(z_q);
	assign turn_sat = (turn_sum > 33'sd2147483647) ? TURN_MAX
		: (turn_sum < -33'sd2147483648) ? -TURN_MAX - 32'sd1 : turn_sum[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			v_q <= '0;
			nv_q <= '0;
			k_q <= '0;
			i_q <= '0;
			step_q <= '0;
			comp_q <= '0;
			cfg_q <= 8'd3;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
			turn_q <= '0;
			least_q <= TURN_MAX;
			checked_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= VW'(clr_q + 1'b1);
					if (clr_q == VW'(MAX_VERTICES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire && (in_data.cmd == CMD_RUN)) begin
						least_q <= TURN_MAX;
						checked_q <= 1'b0;
						nv_q <= nv_w;
						v_q <= VW'(1);
						state_q <= (nv_w == '0) ? S_DONE : S_VRD;
					end
				end
				S_VRD: state_q <= S_VCHK;
				S_VCHK: begin
					if ((len_rd == '0) || (ring_rd == 8'd0)) begin
						state_q <= S_VNEXT;
					end else begin
						k_q <= LW'(1);
						state_q <= S_WRD;
					end
				end
				S_WRD: state_q <= (k_q < len_q) ? S_WCHK : S_WEND;
				S_WCHK: begin
					if ((ring_rd == 8'd0) || (ring_rd == start_q)) begin
						state_q <= S_WEND;
					end else begin
						k_q <= LW'(k_q + 1'b1);
						state_q <= S_WRD;
					end
				end
				S_WEND: begin
					if (k_q < LW'(3)) begin
						state_q <= S_VNEXT;
					end else begin
						checked_q <= 1'b1;
						i_q <= '0;
						state_q <= S_NRD;
					end
				end
				S_NRD: state_q <= S_NCRD;
				S_NCRD: state_q <= S_DIFF;
				S_DIFF: state_q <= mag_zero ? S_DWR : S_NORM;
				S_NORM: begin
					if (!big_hi && !big_lo) begin
						step_q <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd3) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (bit_q[0]) begin
						step_q <= '0;
						comp_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (step_q == 5'd30) begin
						step_q <= '0;
						if (comp_q == 2'd2) begin
							state_q <= S_DWR;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				S_DWR: begin
					if (LW'(i_q + 1'b1) == k_q) begin
						i_q <= '0;
						turn_q <= '0;
						state_q <= S_A0;
					end else begin
						i_q <= LW'(i_q + 1'b1);
						state_q <= S_NRD;
					end
				end
				S_A0: state_q <= S_A1;
				S_A1: state_q <= S_A2;
				S_A2: state_q <= S_A3;
				S_A3: begin
					step_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(MUL_LAST)) begin
						state_q <= S_CINIT;
					end
				end
				S_CINIT: begin
					step_q <= '0;
					state_q <= ((cx0 == '0) && (cy0 == '0)) ? S_TURN : S_CORD;
				end
				S_CORD: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(CORDIC_STEPS - 1)) begin
						state_q <= S_TURN;
					end
				end
				S_TURN: begin
					turn_q <= turn_sat;
					i_q <= LW'(i_q + 1'b1);
					state_q <= (LW'(i_q + 1'b1) == k_q) ? S_VEND : S_A0;
				end
				S_VEND: begin
					if (turn_q < least_q) begin
						least_q <= turn_q;
					end
					state_q <= S_VNEXT;
				end
				S_VNEXT: begin
					if (v_q == nv_q) begin
						state_q <= S_DONE;
					end else begin
						v_q <= VW'(v_q + 1'b1);
						state_q <= S_VRD;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_data_q.min_turn <= least_q;
						out_data_q.dent <= (least_q <= 32'sd0);
						out_data_q.none_checked <= !checked_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_VCHK: begin
				len_q <= len_rd;
				start_q <= ring_rd;
				cv_q <= coord_rd;
			end
			S_NCRD: nb_ok_q <= (32'(ring_rd) < MAX_VERTICES);
			S_DIFF: begin
				for (int j = 0; j < 3; j++) begin
					m_q[j] <= mag[j];
					neg_q[j] <= diff[j][48];
					dir_q[j] <= '0;
				end
			end
			S_NORM: begin
				for (int j = 0; j < 3; j++) begin
					if (big_hi) begin
						m_q[j] <= m_q[j] >> 1;
					end else if (big_lo) begin
						m_q[j] <= m_q[j] << 1;
					end
				end
			end
			S_SQ: begin
				prod_q <= prod[63:0];
				if (step_q == '0) begin
					sum_q <= '0;
				end else begin
					sum_q <= sum_q + prod_q[62:0];
				end
				res_q <= '0;
				bit_q <= {1'b1, 62'b0};
			end
			S_SQRT: begin
				if (sum_q >= sq_trial) begin
					sum_q <= sum_q - sq_trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DIV: begin
				q_q <= q_n;
				r_q <= div_ge ? 31'(div_t - {1'b0, res_q[30:0]}) : div_t[30:0];
				if (step_q == 5'd30) begin
					dir_q[comp_q] <= neg_q[comp_q] ? -q_s : q_s;
				end
			end
			S_A1: begin
				a_q[0] <= $signed(dir_rd[31:0]);
				a_q[1] <= $signed(dir_rd[63:32]);
				a_q[2] <= $signed(dir_rd[95:64]);
			end
			S_A2: begin
				b_q[0] <= $signed(dir_rd[31:0]);
				b_q[1] <= $signed(dir_rd[63:32]);
				b_q[2] <= $signed(dir_rd[95:64]);
			end
			S_A3: begin
				c_q[0] <= $signed(dir_rd[31:0]);
				c_q[1] <= $signed(dir_rd[63:32]);
				c_q[2] <= $signed(dir_rd[95:64]);
				act_q <= ACT_NONE;
			end
			S_MUL: begin
				prod_q <= prod[63:0];
				act_q <= cur_act;
				case (act_q)
					ACT_LOAD: acc_q <= prod_q;
					ACT_ADD: acc_q <= acc_sum;
					ACT_CX: cx_q <= acc_dif[63:30];
					ACT_CY: cy_q <= acc_dif[63:30];
					ACT_CZ: cz_q <= acc_dif[63:30];
					ACT_NUM: num_q <= acc_sum;
					ACT_AB: ab_q <= clamp_dot(acc_sum);
					ACT_BC: bc_q <= clamp_dot(acc_sum);
					ACT_AC: ac_q <= clamp_dot(acc_sum);
					ACT_DEN: acc_q <= prod_q - (64'(ac_q) <<< 30);
					default: ;
				endcase
			end
			S_CINIT: begin
				if ((cx0 == '0) && (cy0 == '0)) begin
					z_q <= '0;
				end else if (cx0 < 0) begin
					z_q <= (cy0 >= 0) ? ANG_PI : -ANG_PI;
					x_q <= -cx0;
					y_q <= -cy0;
				end else begin
					z_q <= '0;
					x_q <= cx0;
					y_q <= cy0;
				end
			end
			S_CORD: begin
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_entry(step_q);
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_entry(step_q);
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/vlmt_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module vlmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
